// File: rtl/dual_fan_thermal_controller_unit_assert.svh
`ifndef DUAL_FAN_THERMAL_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_FAN_THERMAL_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define DFTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dftc same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define DFTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dftc next-cycle check failed");

`endif

// File: rtl/dftc_pkg.sv
`default_nettype none

package dftc_pkg;

  localparam int TEMP_W = 12;
  localparam int CODE_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SETPOINT      = 3'd0,
    REG_BOOST_MARGIN  = 3'd1,
    REG_SLOPE_STEP    = 3'd2,
    REG_GRADIENT_HIGH = 3'd3,
    REG_GRADIENT_LOW  = 3'd4,
    REG_FAN_ON_CODE   = 3'd5,
    REG_FAN_MAX_CODE  = 3'd6,
    REG_FAULT_LIMIT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic [9:0]               boost_margin;
    logic [6:0]               slope_step;
    logic [9:0]               gradient_high;
    logic [9:0]               gradient_low;
    logic [CODE_W-1:0]        fan_on_code;
    logic [CODE_W-1:0]        fan_max_code;
    logic signed [TEMP_W-1:0] fault_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    setpoint:      12'sd210,
    boost_margin:  10'd30,
    slope_step:    7'd2,
    gradient_high: 10'd50,
    gradient_low:  10'd30,
    fan_on_code:   8'd253,
    fan_max_code:  8'd254,
    fault_limit:   -12'sd950
  };

  typedef struct packed {
    logic signed [TEMP_W-1:0] prev_top;
    logic signed [TEMP_W-1:0] prev_bottom;
    logic [CODE_W-1:0]        prev_inner;
    logic [CODE_W-1:0]        prev_outer;
  } state_t;

  typedef struct packed {
    logic              sensor_fault;
    logic [CODE_W-1:0] inner_code;
    logic [CODE_W-1:0] outer_code;
    logic              inner_changed;
    logic              outer_changed;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/dftc_cfg.sv
`default_nettype none

module dftc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dftc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [dftc_pkg::DATA_W-1:0]    pwdata,
  output logic      [dftc_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  output dftc_pkg::cfg_t                      cfg
);

  dftc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = dftc_pkg::reg_idx_t'(paddr[dftc_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= dftc_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        dftc_pkg::REG_SETPOINT:      cfg.setpoint      <= pwdata[11:0];
        dftc_pkg::REG_BOOST_MARGIN:  cfg.boost_margin  <= pwdata[9:0];
        dftc_pkg::REG_SLOPE_STEP:    cfg.slope_step    <= pwdata[6:0];
        dftc_pkg::REG_GRADIENT_HIGH: cfg.gradient_high <= pwdata[9:0];
        dftc_pkg::REG_GRADIENT_LOW:  cfg.gradient_low  <= pwdata[9:0];
        dftc_pkg::REG_FAN_ON_CODE:   cfg.fan_on_code   <= pwdata[7:0];
        dftc_pkg::REG_FAN_MAX_CODE:  cfg.fan_max_code  <= pwdata[7:0];
        dftc_pkg::REG_FAULT_LIMIT:   cfg.fault_limit   <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  // Signed registers read back sign extended.
  always_comb begin
    case (idx)
      dftc_pkg::REG_SETPOINT:      prdata = {{20{cfg.setpoint[11]}}, cfg.setpoint};
      dftc_pkg::REG_BOOST_MARGIN:  prdata = {22'd0, cfg.boost_margin};
      dftc_pkg::REG_SLOPE_STEP:    prdata = {25'd0, cfg.slope_step};
      dftc_pkg::REG_GRADIENT_HIGH: prdata = {22'd0, cfg.gradient_high};
      dftc_pkg::REG_GRADIENT_LOW:  prdata = {22'd0, cfg.gradient_low};
      dftc_pkg::REG_FAN_ON_CODE:   prdata = {24'd0, cfg.fan_on_code};
      dftc_pkg::REG_FAN_MAX_CODE:  prdata = {24'd0, cfg.fan_max_code};
      dftc_pkg::REG_FAULT_LIMIT:   prdata = {{20{cfg.fault_limit[11]}}, cfg.fault_limit};
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/dftc_law.sv
`default_nettype none

module dftc_law (
  input  wire dftc_pkg::cfg_t                  cfg,
  input  wire dftc_pkg::state_t                state,
  input  wire logic signed [dftc_pkg::TEMP_W-1:0] bottom_temp,
  input  wire logic signed [dftc_pkg::TEMP_W-1:0] top_temp,
  output dftc_pkg::result_t                    res,
  output dftc_pkg::state_t                     state_next
);

  localparam int WW = 15;  // wide enough for a gradient minus the previous gradient
  localparam int CW = 10;  // code plus two steps of headroom before the clamp

  logic signed [WW-1:0] top_x, bot_x, ptop_x, pbot_x, sp_x;
  logic signed [WW-1:0] margin_x, step_x, gh_x, gl_x;
  logic signed [WW-1:0] excess, slope, grad, prev_grad, grad_delta;
  logic                 fault, hot, boost, rise, fall;
  logic [CW-1:0]        on_x, mx_x, in_base, out_base, out_boost, out_adj, in_adj;
  logic [CW-1:0]        in_hot, out_hot;
  logic [dftc_pkg::CODE_W-1:0] inner, outer;

  always_comb begin
    top_x    = {{(WW-12){top_temp[11]}}, top_temp};
    bot_x    = {{(WW-12){bottom_temp[11]}}, bottom_temp};
    ptop_x   = {{(WW-12){state.prev_top[11]}}, state.prev_top};
    pbot_x   = {{(WW-12){state.prev_bottom[11]}}, state.prev_bottom};
    sp_x     = {{(WW-12){cfg.setpoint[11]}}, cfg.setpoint};
    margin_x = {{(WW-10){1'b0}}, cfg.boost_margin};
    step_x   = {{(WW-7){1'b0}}, cfg.slope_step};
    gh_x     = {{(WW-10){1'b0}}, cfg.gradient_high};
    gl_x     = {{(WW-10){1'b0}}, cfg.gradient_low};
    on_x     = {2'b00, cfg.fan_on_code};
    mx_x     = {2'b00, cfg.fan_max_code};

    fault = (bottom_temp < cfg.fault_limit) || (top_temp < cfg.fault_limit);
    hot   = top_temp > cfg.setpoint;

    // A fan that was off starts from the switch-on code.
    in_base  = (state.prev_inner != '0) ? {2'b00, state.prev_inner} : on_x;
    out_base = (state.prev_outer != '0) ? {2'b00, state.prev_outer} : on_x;

    // Outer fan: boost on large excess, then follow the top slope.
    excess    = top_x - sp_x;
    boost     = excess > margin_x;
    slope     = top_x - ptop_x;
    rise      = slope > step_x;
    fall      = slope < -step_x;
    out_boost = boost ? out_base + 10'd1 : out_base;
    if (rise)
      out_adj = out_boost + 10'd1;
    else if (fall && (out_boost > on_x))
      out_adj = out_boost - 10'd1;
    else
      out_adj = out_boost;

    // Inner fan: follow the top-to-bottom gradient and its change.
    grad       = top_x - bot_x;
    prev_grad  = ptop_x - pbot_x;
    grad_delta = grad - prev_grad;
    in_adj     = in_base;
    if (grad > gh_x) begin
      if (({2'b00, state.prev_inner} >= on_x) && (grad_delta > step_x))
        in_adj = in_base + 10'd1;
    end else if (grad < gl_x) begin
      if ({2'b00, state.prev_inner} > on_x)
        in_adj = in_base - 10'd1;
    end

    in_hot  = hot ? in_adj : '0;
    out_hot = hot ? out_adj : '0;
    inner   = (in_hot > mx_x) ? cfg.fan_max_code : in_hot[dftc_pkg::CODE_W-1:0];
    outer   = (out_hot > mx_x) ? cfg.fan_max_code : out_hot[dftc_pkg::CODE_W-1:0];

    if (fault) begin
      res.sensor_fault  = 1'b1;
      res.inner_code    = state.prev_inner;
      res.outer_code    = state.prev_outer;
      res.inner_changed = 1'b0;
      res.outer_changed = 1'b0;
      state_next        = state;
    end else begin
      res.sensor_fault       = 1'b0;
      res.inner_code         = inner;
      res.outer_code         = outer;
      res.inner_changed      = inner != state.prev_inner;
      res.outer_changed      = outer != state.prev_outer;
      state_next.prev_top    = top_temp;
      state_next.prev_bottom = bottom_temp;
      state_next.prev_inner  = inner;
      state_next.prev_outer  = outer;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dual_fan_thermal_controller_unit.sv
// Path: an accepted item passes the input register, then the result register, which sets out_valid.
// Throughput: one item per cycle while the output is not stalled; state and result load on one edge.
// Backpressure: an output stall holds the result register and, through it, the input register.
// Reset (rst, synchronous, active high): clears both valid flags, the fan state and prior
// readings to zero, and loads the configuration registers with their documented defaults.
`default_nettype none

module dual_fan_thermal_controller_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dftc_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [dftc_pkg::DATA_W-1:0]         pwdata,
  output logic      [dftc_pkg::DATA_W-1:0]         prdata,
  output logic                                     pready,
  // reading channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [dftc_pkg::TEMP_W-1:0]  bottom_temp,
  input  wire logic signed [dftc_pkg::TEMP_W-1:0]  top_temp,
  // fan code channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     sensor_fault,
  output logic      [dftc_pkg::CODE_W-1:0]         inner_code,
  output logic      [dftc_pkg::CODE_W-1:0]         outer_code,
  output logic                                     inner_changed,
  output logic                                     outer_changed
);

  dftc_pkg::cfg_t    cfg;
  dftc_pkg::state_t  state, state_next;
  dftc_pkg::result_t res;

  logic                              s1_valid;
  logic signed [dftc_pkg::TEMP_W-1:0] s1_bottom, s1_top;
  logic                              in_fire, out_load, s1_adv;
  logic                              codes_match;

  dftc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register takes a new item when it is empty or being drained.
  // The input register moves on whenever the result register loads, so a
  // new reading can enter in the same cycle as the last one leaves.
  assign out_load = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bottom <= bottom_temp;
      s1_top    <= top_temp;
    end
  end

  // Control law on the registered readings against the running fan state.
  dftc_law u_law (
    .cfg         (cfg),
    .state       (state),
    .bottom_temp (s1_bottom),
    .top_temp    (s1_top),
    .res         (res),
    .state_next  (state_next)
  );

  // Advance the fan state as the item moves into the result register; a
  // faulty reading hands back the old state unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sensor_fault  <= res.sensor_fault;
      inner_code    <= res.inner_code;
      outer_code    <= res.outer_code;
      inner_changed <= res.inner_changed;
      outer_changed <= res.outer_changed;
    end
  end

  assign codes_match = (state.prev_inner == inner_code) && (state.prev_outer == outer_code);

`include "dual_fan_thermal_controller_unit_assert.svh"

  // A held good result always matches the fan state it left behind.
  `DFTC_ASSERT_NOW(a_state_tracks_result, out_valid && !sensor_fault, codes_match)
  // A faulty reading leaves the previous readings alone.
  `DFTC_ASSERT_NXT(a_fault_keeps_state, s1_adv && res.sensor_fault, state == $past(state))
  // Input backpressure only arises with an item waiting in the input register.
  `DFTC_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid && out_valid)

endmodule

`default_nettype wire
